@@ sv/humidity_sensor_two_wire_master_macros.svh @@
// assertion macros for the humidity sensor two-wire master
`ifndef HUMIDITY_SENSOR_TWO_WIRE_MASTER_MACROS_SVH
`define HUMIDITY_SENSOR_TWO_WIRE_MASTER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HSTWM_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("hstwm same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define HSTWM_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("hstwm next-cycle check failed");

`endif

@@ sv/hstwm_pkg.sv @@
// types, command codes and slot tables for the humidity sensor two-wire master
package hstwm_pkg;

    // command codes carried in func
    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_LINE_RESET = 3'd1;
    localparam logic [2:0] CMD_START      = 3'd2;
    localparam logic [2:0] CMD_WRITE      = 3'd3;
    localparam logic [2:0] CMD_READ_ACK   = 3'd4;
    localparam logic [2:0] CMD_READ_CRC   = 3'd5;

    // clock pulses in a line reset (effective 1 to 32)
    localparam logic [5:0] RESET_PULSES = 6'd10;

    // start condition, indexed by slot 0..6
    localparam logic [6:0] START_CLK  = 7'b0110110;
    localparam logic [6:0] START_PULL = 7'b0011100;
    localparam logic [4:0] START_LAST = 5'd6;

    // byte transfer slot landmarks
    localparam logic [4:0] SLOT_ACK    = 5'd16;
    localparam logic [4:0] SLOT_ACK_HI = 5'd17;
    localparam logic [4:0] SLOT_MAX    = 5'd31;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] write_value;
        logic       data_line_in;
        logic       poll_ready;
    } hstwm_in_t;

    typedef struct packed {
        logic       clock_level;
        logic       data_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       ack_level;
    } hstwm_res_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [4:0] step;
        logic [3:0] bit_count;
        logic [7:0] shift;
        logic       ack;
    } hstwm_state_t;

endpackage

@@ sv/humidity_sensor_two_wire_master.sv @@
// top level of the humidity sensor two-wire master
// an accepted input beat waits in the input register, then moves to the result register
// throughput: one beat per cycle while m_ready is high, set by the single register pass
// each input beat is one bus time slot and yields exactly one result beat
// reset (aresetn low, synchronous): both stages empty, sequencer idle, shift and ack cleared
module humidity_sensor_two_wire_master (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_func,
    input  logic [7:0] s_write_value,
    input  logic       s_data_line_in,
    input  logic       s_poll_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_clock_level,
    output logic       m_data_pull_low,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_read_value,
    output logic       m_ack_level
);
    import hstwm_pkg::*;

`include "humidity_sensor_two_wire_master_macros.svh"

    // input stage
    logic         in_valid_reg;
    hstwm_in_t    in_reg;

    // sequencer state, advanced once per processed slot
    hstwm_state_t state_reg;
    hstwm_state_t state_next;

    // result stage
    logic         out_valid_reg;
    hstwm_res_t   out_reg;
    hstwm_res_t   res_next;

    logic         advance;

    // a slot moves from input to result register when the result side has room;
    // the input side refills in the same cycle, so beats flow back to back
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    hstwm_step u_step (
        .beat_in   (in_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .res       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            // input register takes a beat whenever it is empty or draining
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            // result register empties on a taken beat and refills on advance
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg.func         <= s_func;
            in_reg.write_value  <= s_write_value;
            in_reg.data_line_in <= s_data_line_in;
            in_reg.poll_ready   <= s_poll_ready;
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_clock_level   = out_reg.clock_level;
    assign m_data_pull_low = out_reg.data_pull_low;
    assign m_busy_res      = out_reg.busy_res;
    assign m_done_res      = out_reg.done_res;
    assign m_read_value    = out_reg.read_value;
    assign m_ack_level     = out_reg.ack_level;

    // idle sequencer never carries a stale slot or pulse phase
    `HSTWM_ASSERT_IMP(a_idle_clean, aclk, aresetn, state_reg.cmd == CMD_NONE,
                      state_reg.step == 5'd0 && state_reg.bit_count == 4'd0)
    // a finished command leaves the sequencer idle
    `HSTWM_ASSERT_NXT(a_done_to_idle, aclk, aresetn,
                      advance && res_next.done_res && res_next.busy_res,
                      state_reg.cmd == CMD_NONE)
    // a received byte only shows in the done slot of a running command
    `HSTWM_ASSERT_IMP(a_read_in_done, aclk, aresetn, m_valid && m_read_value != 8'd0,
                      m_done_res && m_busy_res)
    // ack level only comes with done
    `HSTWM_ASSERT_IMP(a_ack_in_done, aclk, aresetn, m_valid && m_ack_level, m_done_res)

endmodule

@@ sv/hstwm_step.sv @@
// one bus slot of the sequencer: next state and slot result
module hstwm_step (
    input  hstwm_pkg::hstwm_in_t    beat_in,
    input  hstwm_pkg::hstwm_state_t state_cur,
    output hstwm_pkg::hstwm_state_t state_nxt,
    output hstwm_pkg::hstwm_res_t   res
);
    import hstwm_pkg::*;

    hstwm_state_t w;
    logic         run;
    logic [5:0]   pulse_sum;
    logic [4:0]   s;

    always_comb begin
        w         = state_cur;
        run       = 1'b1;
        res       = '0;
        pulse_sum = 6'd0;
        s         = 5'd0;

        // idle: take a command or answer a poll
        if (state_cur.cmd == CMD_NONE) begin
            if (beat_in.func >= CMD_LINE_RESET && beat_in.func <= CMD_READ_CRC) begin
                w.cmd       = beat_in.func;
                w.step      = 5'd0;
                w.bit_count = 4'd0;
                w.ack       = 1'b0;
                w.shift     = (beat_in.func == CMD_WRITE) ? beat_in.write_value : 8'd0;
            end else begin
                run = 1'b0;
                if (beat_in.poll_ready) begin
                    res.done_res  = 1'b1;
                    res.ack_level = ~beat_in.data_line_in;
                end
            end
        end

        if (run) begin
            res.busy_res = 1'b1;
            s            = w.step;
            unique case (w.cmd) inside
                CMD_LINE_RESET: begin
                    if (!w.bit_count[0]) begin
                        res.clock_level = 1'b1;
                        w.bit_count     = 4'd1;
                    end else begin
                        pulse_sum = {1'b0, s} + 6'd1;
                        if (pulse_sum >= RESET_PULSES || s == SLOT_MAX) begin
                            res.done_res = 1'b1;
                        end else begin
                            w.step      = s + 5'd1;
                            w.bit_count = 4'd0;
                        end
                    end
                end
                CMD_START: begin
                    if (s > START_LAST) begin
                        s = START_LAST;
                    end
                    res.clock_level   = START_CLK[s[2:0]];
                    res.data_pull_low = START_PULL[s[2:0]];
                    res.done_res      = (s == START_LAST);
                end
                CMD_WRITE: begin
                    if (s < SLOT_ACK) begin
                        res.clock_level   = s[0];
                        res.data_pull_low = ~w.shift[7];
                        if (s[0]) begin
                            w.shift = {w.shift[6:0], 1'b0};
                        end
                    end else if (s == SLOT_ACK) begin
                        w.ack = beat_in.data_line_in;
                    end else if (s == SLOT_ACK_HI) begin
                        res.clock_level = 1'b1;
                    end else begin
                        res.done_res  = 1'b1;
                        res.ack_level = w.ack;
                    end
                end
                CMD_READ_ACK, CMD_READ_CRC: begin
                    if (s < SLOT_ACK) begin
                        res.clock_level = s[0];
                        if (!s[0]) begin
                            if (w.cmd == CMD_READ_ACK) begin
                                w.shift = {w.shift[6:0], beat_in.data_line_in};
                            end else begin
                                // crc arrives lsb first, each bit enters at the top
                                w.shift = {beat_in.data_line_in, w.shift[7:1]};
                            end
                        end
                    end else if (s == SLOT_ACK || s == SLOT_ACK_HI) begin
                        res.clock_level   = (s == SLOT_ACK_HI);
                        res.data_pull_low = (w.cmd == CMD_READ_ACK);
                    end else begin
                        res.done_res   = 1'b1;
                        res.read_value = w.shift;
                    end
                end
                default: begin
                    res.done_res = 1'b1;
                end
            endcase

            if (res.done_res) begin
                w.cmd       = CMD_NONE;
                w.step      = 5'd0;
                w.bit_count = 4'd0;
            end else if (w.cmd != CMD_LINE_RESET) begin
                w.step = w.step + 5'd1;
            end
        end

        state_nxt = w;
    end

endmodule

@@ sim/hstwm_slot_checker.sv @@
// slot predictor and result checker for the two-wire sensor master
`timescale 1ns / 1ps

module hstwm_slot_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [2:0] s_func,
    input  logic [7:0] s_write_value,
    input  logic       s_data_line_in,
    input  logic       s_poll_ready,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_clock_level,
    input  logic       m_data_pull_low,
    input  logic       m_busy_res,
    input  logic       m_done_res,
    input  logic [7:0] m_read_value,
    input  logic       m_ack_level,
    output int         fail_count,
    output int         pending_count
);
    import hstwm_pkg::*;

    localparam int REPORT_LIMIT = 60;

    hstwm_state_t sensor_seq;
    hstwm_res_t   expected_slots[$];
    hstwm_res_t   want;
    logic         bad;
    int           reported;

    // bus sequencer model, one call per accepted slot
    function automatic hstwm_res_t predict_slot(hstwm_in_t beat);
        hstwm_res_t r;
        logic [4:0] slot;
        logic       finished;
        r = '0;
        finished = 1'b0;
        if (sensor_seq.cmd == CMD_NONE) begin
            if (beat.func >= CMD_LINE_RESET && beat.func <= CMD_READ_CRC) begin
                sensor_seq.cmd       = beat.func;
                sensor_seq.step      = '0;
                sensor_seq.bit_count = '0;
                sensor_seq.ack       = 1'b0;
                sensor_seq.shift     = (beat.func == CMD_WRITE) ? beat.write_value : 8'h00;
            end else begin
                // idle slot, poll answered at once
                if (beat.poll_ready) begin
                    r.done_res  = 1'b1;
                    r.ack_level = !beat.data_line_in;
                end
                return r;
            end
        end
        slot = sensor_seq.step;
        r.busy_res = 1'b1;
        case (sensor_seq.cmd)
            CMD_LINE_RESET: begin
                if (!sensor_seq.bit_count[0]) begin
                    r.clock_level = 1'b1;
                    sensor_seq.bit_count = 4'd1;
                end else if (int'(slot) + 1 >= int'(RESET_PULSES) || slot == 5'd31) begin
                    finished = 1'b1;
                end else begin
                    sensor_seq.step = slot + 5'd1;
                    sensor_seq.bit_count = '0;
                end
            end
            CMD_START: begin
                if (slot > 5'd6) slot = 5'd6;
                r.clock_level   = (slot == 5'd1 || slot == 5'd2 || slot == 5'd4 || slot == 5'd5);
                r.data_pull_low = (slot >= 5'd2 && slot <= 5'd4);
                finished        = (slot == 5'd6);
            end
            CMD_WRITE: begin
                if (slot < 5'd16) begin
                    r.clock_level   = slot[0];
                    r.data_pull_low = !sensor_seq.shift[7];
                    if (slot[0]) sensor_seq.shift = {sensor_seq.shift[6:0], 1'b0};
                end else if (slot == 5'd16) begin
                    sensor_seq.ack = beat.data_line_in;
                end else if (slot == 5'd17) begin
                    r.clock_level = 1'b1;
                end else begin
                    finished    = 1'b1;
                    r.ack_level = sensor_seq.ack;
                end
            end
            CMD_READ_ACK, CMD_READ_CRC: begin
                if (slot < 5'd16) begin
                    r.clock_level = slot[0];
                    if (!slot[0]) begin
                        if (sensor_seq.cmd == CMD_READ_ACK)
                            sensor_seq.shift = {sensor_seq.shift[6:0], beat.data_line_in};
                        else
                            sensor_seq.shift = {beat.data_line_in, sensor_seq.shift[7:1]};
                    end
                end else if (slot == 5'd16 || slot == 5'd17) begin
                    r.clock_level   = (slot == 5'd17);
                    r.data_pull_low = (sensor_seq.cmd == CMD_READ_ACK);
                end else begin
                    finished     = 1'b1;
                    r.read_value = sensor_seq.shift;
                end
            end
            default: finished = 1'b1;
        endcase
        if (finished) begin
            sensor_seq.cmd       = CMD_NONE;
            sensor_seq.step      = '0;
            sensor_seq.bit_count = '0;
        end else if (sensor_seq.cmd != CMD_LINE_RESET) begin
            sensor_seq.step = sensor_seq.step + 5'd1;
        end
        r.done_res = finished;
        return r;
    endfunction

    function automatic logic field_differs(string field, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v === act_v) return 1'b0;
        if (reported < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        else if (reported == REPORT_LIMIT)
            $display("%0t: further mismatch reports suppressed", $time);
        reported++;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            sensor_seq = '0;
            expected_slots.delete();
            reported = 0;
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            // compare before pushing so a stray beat cannot match this edge's input
            if (m_valid && m_ready) begin
                if (expected_slots.size() == 0) begin
                    if (reported < REPORT_LIMIT)
                        $display("%0t: result beat with no slot pending, expected none, actual %0h",
                                 $time, {m_clock_level, m_data_pull_low, m_busy_res,
                                         m_done_res, m_read_value, m_ack_level});
                    reported++;
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_slots.pop_front();
                    bad = 1'b0;
                    bad |= field_differs("clock_level", 8'(want.clock_level),
                                         8'(m_clock_level));
                    bad |= field_differs("data_pull_low", 8'(want.data_pull_low),
                                         8'(m_data_pull_low));
                    bad |= field_differs("busy_res", 8'(want.busy_res), 8'(m_busy_res));
                    bad |= field_differs("done_res", 8'(want.done_res), 8'(m_done_res));
                    bad |= field_differs("read_value", want.read_value, m_read_value);
                    bad |= field_differs("ack_level", 8'(want.ack_level), 8'(m_ack_level));
                    if (bad) fail_count <= fail_count + 1;
                end
            end
            if (s_valid && s_ready)
                expected_slots.push_back(predict_slot({s_func, s_write_value,
                                                       s_data_line_in, s_poll_ready}));
            pending_count <= expected_slots.size();
        end
    end

endmodule

@@ sim/tb_humidity_sensor_two_wire_master.sv @@
// testbench top: slot stimulus, bus stalls and verdict for the two-wire sensor master
`timescale 1ns / 1ps

module tb_humidity_sensor_two_wire_master;
    import hstwm_pkg::*;

    // slots per command sequence; a line reset gives at least one and at most 32 pulses
    localparam int LINE_RESET_SLOTS =
        2 * ((RESET_PULSES < 1) ? 1 : ((RESET_PULSES > 32) ? 32 : int'(RESET_PULSES)));
    localparam int START_SLOTS      = 7;
    localparam int BYTE_SLOTS       = 19;

    localparam int TOTAL_BEATS      = 1550;
    localparam int QUIET_FROM       = 1350;   // no idling on either side past this beat
    localparam int HOLD_FROM        = 500;    // long receiver hold-off around here
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int WATCHDOG_LIMIT   = 1000;   // cycles with no beat on either channel
    localparam int DRAIN_CYCLES     = 10;     // two-stage pipe, settle time after the drain

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [2:0] s_func         = CMD_NONE;
    logic [7:0] s_write_value  = 8'h00;
    logic       s_data_line_in = 1'b1;
    logic       s_poll_ready   = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic       m_clock_level;
    logic       m_data_pull_low;
    logic       m_busy_res;
    logic       m_done_res;
    logic [7:0] m_read_value;
    logic       m_ack_level;

    int fail_count;
    int pending_count;

    // stimulus bookkeeping, also used for the run summary
    int beats_sent = 0;
    int polls_sent = 0;
    int offered[8] = '{default: 0};
    int idle_cycles = 0;
    bit quiet_phase = 1'b0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    humidity_sensor_two_wire_master i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_write_value   (s_write_value),
        .s_data_line_in  (s_data_line_in),
        .s_poll_ready    (s_poll_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_clock_level   (m_clock_level),
        .m_data_pull_low (m_data_pull_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_read_value    (m_read_value),
        .m_ack_level     (m_ack_level)
    );

    // watches both channels, predicts every slot and compares result beats
    hstwm_slot_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_write_value   (s_write_value),
        .s_data_line_in  (s_data_line_in),
        .s_poll_ready    (s_poll_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_clock_level   (m_clock_level),
        .m_data_pull_low (m_data_pull_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_read_value    (m_read_value),
        .m_ack_level     (m_ack_level),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    // offer one slot beat and hold it until accepted; sometimes idle first
    task automatic send_beat(input logic [2:0] func, input logic [7:0] wv,
                             input logic din, input logic pr);
        if (!quiet_phase && $urandom_range(0, 11) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= func;
        s_write_value  <= wv;
        s_data_line_in <= din;
        s_poll_ready   <= pr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        if (func >= CMD_LINE_RESET && func <= CMD_READ_CRC) offered[func]++;
        if (pr) polls_sent++;
    endtask

    // one command plus the filler slots it runs for; line_bits[k] is the data line in slot k,
    // junk_pct is the chance that a filler slot carries a command that must be ignored
    task automatic run_command(input logic [2:0] cmd, input logic [7:0] wv,
                               input logic [63:0] line_bits, input logic pr_first,
                               input int junk_pct);
        int n_slots;
        case (cmd)
            CMD_LINE_RESET: n_slots = LINE_RESET_SLOTS;
            CMD_START:      n_slots = START_SLOTS;
            default:        n_slots = BYTE_SLOTS;
        endcase
        send_beat(cmd, wv, line_bits[0], pr_first);
        for (int k = 1; k < n_slots; k++) begin
            if ($urandom_range(0, 99) < junk_pct)
                send_beat(3'($urandom_range(1, 7)), 8'($urandom), line_bits[k], 1'($urandom));
            else
                send_beat(CMD_NONE, 8'($urandom), line_bits[k], 1'($urandom));
        end
    endtask

    // receiver side: random stall bursts, one long hold-off, none in the quiet tail
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold_req && !long_hold_done) begin
                // sender keeps offering, so the pipe fills and s_ready drops
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_done = 1'b1;
                m_ready <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: polls with the line low and high, unused codes treated as idle
        send_beat(CMD_NONE, 8'h00, 1'b0, 1'b1);
        send_beat(CMD_NONE, 8'hff, 1'b1, 1'b1);
        send_beat(3'd6, 8'h5a, 1'b0, 1'b1);
        send_beat(3'd7, 8'ha5, 1'b1, 1'b0);
        // line reset and start, polls during the sequence must be ignored
        run_command(CMD_LINE_RESET, 8'h00, '1, 1'b0, 0);
        run_command(CMD_START, 8'h00, '1, 1'b1, 0);
        // writes at both byte extremes, ack sampled low and high
        run_command(CMD_WRITE, 8'h00, '0, 1'b0, 0);
        run_command(CMD_WRITE, 8'hff, '1, 1'b0, 0);
        // commands on every busy slot including the done slot
        run_command(CMD_WRITE, 8'ha5, {$urandom, $urandom}, 1'b1, 100);
        // reads with the line all high, all low, then two crc reads
        run_command(CMD_READ_ACK, 8'h00, '1, 1'b0, 0);
        run_command(CMD_READ_ACK, 8'hff, '0, 1'b0, 0);
        run_command(CMD_READ_CRC, 8'h00, 64'h0000_0000_0000_4411, 1'b0, 0);
        run_command(CMD_READ_CRC, 8'h00, '1, 1'b0, 100);
        send_beat(CMD_NONE, 8'h00, 1'b0, 1'b1);

        // random: mostly well-formed sequences with random content, some raw noise
        while (beats_sent < TOTAL_BEATS) begin
            if ($urandom_range(0, 3) != 0)
                run_command(3'($urandom_range(1, 5)), 8'($urandom), {$urandom, $urandom},
                            1'($urandom), ($urandom_range(0, 2) == 0) ? 25 : 0);
            else
                repeat ($urandom_range(1, 6))
                    send_beat(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            if (beats_sent > HOLD_FROM) long_hold_req = 1'b1;
            if (beats_sent > QUIET_FROM) quiet_phase = 1'b1;
        end
        s_valid <= 1'b0;

        // drain outstanding results, then a short settle
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d slot beats with %0d poll requests", beats_sent, polls_sent);
        $display("commands offered: reset %0d, start %0d, write %0d, read %0d, crc %0d",
                 offered[CMD_LINE_RESET], offered[CMD_START], offered[CMD_WRITE],
                 offered[CMD_READ_ACK], offered[CMD_READ_CRC]);
        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/hstwm_pkg.sv
sv/hstwm_step.sv
sv/humidity_sensor_two_wire_master.sv
sim/hstwm_slot_checker.sv
sim/tb_humidity_sensor_two_wire_master.sv
